FILE: rtl/core/mrac_pkg.sv
// ----------------------------------------------------------------------------
// mrac_pkg: shared types and constants of the perceptron classifier
// Sequencer states, store sections, the default network table and the
// control structs that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mrac_pkg;

  localparam int DATA_W      = 16;
  localparam int PROD_W      = 32;
  localparam int ACC_W       = 40;
  // Index fields wide enough for the largest layer size that is supported.
  localparam int IDX_W       = 6;
  localparam int FEAT_PORTS  = 9;
  localparam int FEAT_IW     = 4;
  localparam int N_DEFAULTS  = 42;

  localparam logic signed [DATA_W-1:0] ONE_Q88 = 16'sd256;

  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HID,
    ST_WAIT_H,
    ST_OUT,
    ST_WAIT_O
  } state_t;

  typedef enum logic [1:0] {
    SEC_HW,
    SEC_HB,
    SEC_OW,
    SEC_OB
  } section_t;

  typedef struct packed {
    section_t                  kind;
    logic [6:0]                row;
    logic [6:0]                col;
    logic signed [DATA_W-1:0]  val;
  } init_entry_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             out_layer;
    logic             load_feat;
    logic [IDX_W-1:0] fidx;
    logic [IDX_W-1:0] unit;
  } mac_ctl_t;

  typedef struct packed {
    logic hid_done;
    logic out_done;
  } mac_sts_t;

  localparam init_entry_t DEFAULTS [N_DEFAULTS] = '{
    '{SEC_HW, 7'd0,  7'd1,  16'sd512},  '{SEC_HW, 7'd0,  7'd0, -16'sd384},
    '{SEC_HW, 7'd0,  7'd8,  16'sd768},  '{SEC_HB, 7'd0,  7'd0, -16'sd512},
    '{SEC_HW, 7'd1,  7'd4,  16'sd512},  '{SEC_HW, 7'd1,  7'd3, -16'sd256},
    '{SEC_HW, 7'd1,  7'd7,  16'sd768},  '{SEC_HB, 7'd1,  7'd0, -16'sd384},
    '{SEC_HW, 7'd2,  7'd6,  16'sd1024}, '{SEC_HB, 7'd2,  7'd0, -16'sd256},
    '{SEC_HW, 7'd3,  7'd1, -16'sd256},  '{SEC_HW, 7'd3,  7'd4, -16'sd256},
    '{SEC_HW, 7'd3,  7'd6, -16'sd256},  '{SEC_HB, 7'd3,  7'd0,  16'sd512},
    '{SEC_HW, 7'd4,  7'd2, -16'sd512},  '{SEC_HB, 7'd4,  7'd0,  16'sd256},
    '{SEC_HW, 7'd5,  7'd0,  16'sd77},   '{SEC_HW, 7'd5,  7'd2,  16'sd128},
    '{SEC_HW, 7'd6,  7'd7,  16'sd256},  '{SEC_HW, 7'd6,  7'd4,  16'sd128},
    '{SEC_HW, 7'd7,  7'd5, -16'sd128},  '{SEC_HW, 7'd7,  7'd6,  16'sd205},
    '{SEC_HW, 7'd8,  7'd1,  16'sd128},  '{SEC_HW, 7'd8,  7'd2, -16'sd77},
    '{SEC_HW, 7'd9,  7'd3, -16'sd77},   '{SEC_HW, 7'd9,  7'd7,  16'sd128},
    '{SEC_HW, 7'd10, 7'd0,  16'sd51},   '{SEC_HW, 7'd10, 7'd6, -16'sd102},
    '{SEC_HW, 7'd11, 7'd4,  16'sd154},  '{SEC_HW, 7'd11, 7'd3, -16'sd77},
    '{SEC_OW, 7'd0,  7'd0,  16'sd768},  '{SEC_OW, 7'd0,  7'd4, -16'sd384},
    '{SEC_OB, 7'd0,  7'd0, -16'sd768},
    '{SEC_OW, 7'd1,  7'd1,  16'sd768},  '{SEC_OW, 7'd1,  7'd6,  16'sd128},
    '{SEC_OW, 7'd1,  7'd0, -16'sd128},  '{SEC_OB, 7'd1,  7'd0, -16'sd256},
    '{SEC_OW, 7'd2,  7'd2,  16'sd1280}, '{SEC_OW, 7'd2,  7'd0, -16'sd128},
    '{SEC_OB, 7'd2,  7'd0, -16'sd256},
    '{SEC_OW, 7'd3,  7'd3,  16'sd512},  '{SEC_OB, 7'd3,  7'd0, -16'sd256}
  };

  // Default value of one store word; words not in the table are zero.
  function automatic logic signed [DATA_W-1:0] default_word(input section_t   sec,
                                                            input logic [6:0] row,
                                                            input logic [6:0] col);
    logic signed [DATA_W-1:0] v;
    v = '0;
    for (int k = 0; k < N_DEFAULTS; k++) begin
      if (DEFAULTS[k].kind == sec && DEFAULTS[k].row == row && DEFAULTS[k].col == col) begin
        v = DEFAULTS[k].val;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mrac_ram.sv
// ----------------------------------------------------------------------------
// mrac_ram: single-port-write, single-port-read synchronous memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrac_ram #(
  parameter int DEPTH = 172,
  parameter int AW    = 8,
  parameter int W     = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/mrac_seq.sv
// ----------------------------------------------------------------------------
// mrac_seq: sequencer of the classifier
// Loads the default network after reset, takes write and classify commands
// and walks the weight store one word per cycle for both layers.
// ----------------------------------------------------------------------------
`default_nettype none

module mrac_seq #(
  parameter int N_INPUTS  = 9,
  parameter int N_HIDDEN  = 12,
  parameter int N_OUTPUTS = 4,
  parameter int AW        = 8,
  parameter int HAW       = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic                               in_cmd,
  input  wire logic        [7:0]                  in_param_index,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] in_param_value,
  input  wire mrac_pkg::mac_sts_t                 sts,
  output logic                                    busy,
  output logic                                    w_we,
  output logic             [AW-1:0]               w_waddr,
  output logic signed      [mrac_pkg::DATA_W-1:0] w_wdata,
  output logic             [AW-1:0]               w_raddr,
  output logic             [HAW-1:0]              h_raddr,
  output mrac_pkg::mac_ctl_t                      ctl
);

  localparam int HB_BASE     = N_HIDDEN * N_INPUTS;
  localparam int OW_BASE     = HB_BASE + N_HIDDEN;
  localparam int OB_BASE     = OW_BASE + N_OUTPUTS * N_HIDDEN;
  localparam int STORE_WORDS = OB_BASE + N_OUTPUTS;
  localparam int UMAX        = (N_HIDDEN > N_OUTPUTS) ? N_HIDDEN : N_OUTPUTS;
  localparam int SMAX        = (N_INPUTS > N_HIDDEN) ? N_INPUTS : N_HIDDEN;
  localparam int UW          = $clog2(UMAX);
  localparam int SW          = $clog2(SMAX + 1);
  localparam int IW          = mrac_pkg::IDX_W;

  localparam logic [UW-1:0] U_HID_LAST = UW'(N_HIDDEN - 1);
  localparam logic [UW-1:0] U_OUT_LAST = UW'(N_OUTPUTS - 1);
  localparam logic [SW-1:0] S_NI       = SW'(N_INPUTS);
  localparam logic [SW-1:0] S_NH       = SW'(N_HIDDEN);
  localparam logic [SW-1:0] S_NI_LAST  = SW'(N_INPUTS - 1);
  localparam logic [SW-1:0] S_NH_LAST  = SW'(N_HIDDEN - 1);

  mrac_pkg::state_t   state_r, state_nxt;
  mrac_pkg::section_t sec_r, sec_nxt;
  logic [UW-1:0]      unit_r, unit_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic [AW-1:0]      wptr_r, wptr_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrac_pkg::ST_INIT: begin
        if (sec_r == mrac_pkg::SEC_OB && unit_r == U_OUT_LAST) begin
          state_nxt = mrac_pkg::ST_IDLE;
        end
      end
      mrac_pkg::ST_IDLE: begin
        if (start && in_cmd == mrac_pkg::CMD_CLASSIFY) begin
          state_nxt = mrac_pkg::ST_HID;
        end
      end
      mrac_pkg::ST_HID: begin
        if (step_r == S_NI && unit_r == U_HID_LAST) begin
          state_nxt = mrac_pkg::ST_WAIT_H;
        end
      end
      mrac_pkg::ST_WAIT_H: begin
        if (sts.hid_done) begin
          state_nxt = mrac_pkg::ST_OUT;
        end
      end
      mrac_pkg::ST_OUT: begin
        if (step_r == S_NH && unit_r == U_OUT_LAST) begin
          state_nxt = mrac_pkg::ST_WAIT_O;
        end
      end
      mrac_pkg::ST_WAIT_O: begin
        if (sts.out_done) begin
          state_nxt = mrac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mrac_pkg::ST_IDLE;
      end
    endcase
  end

  // Counters: section, row (unit), column (step) and store pointer.
  always_comb begin
    sec_nxt  = sec_r;
    unit_nxt = unit_r;
    step_nxt = step_r;
    wptr_nxt = wptr_r;
    case (state_r)
      mrac_pkg::ST_INIT: begin
        wptr_nxt = wptr_r + AW'(1);
        case (sec_r)
          mrac_pkg::SEC_HW: begin
            if (step_r == S_NI_LAST) begin
              step_nxt = '0;
              if (unit_r == U_HID_LAST) begin
                unit_nxt = '0;
                sec_nxt  = mrac_pkg::SEC_HB;
              end else begin
                unit_nxt = unit_r + UW'(1);
              end
            end else begin
              step_nxt = step_r + SW'(1);
            end
          end
          mrac_pkg::SEC_HB: begin
            if (unit_r == U_HID_LAST) begin
              unit_nxt = '0;
              sec_nxt  = mrac_pkg::SEC_OW;
            end else begin
              unit_nxt = unit_r + UW'(1);
            end
          end
          mrac_pkg::SEC_OW: begin
            if (step_r == S_NH_LAST) begin
              step_nxt = '0;
              if (unit_r == U_OUT_LAST) begin
                unit_nxt = '0;
                sec_nxt  = mrac_pkg::SEC_OB;
              end else begin
                unit_nxt = unit_r + UW'(1);
              end
            end else begin
              step_nxt = step_r + SW'(1);
            end
          end
          default: begin
            unit_nxt = unit_r + UW'(1);
          end
        endcase
      end
      mrac_pkg::ST_IDLE: begin
        if (start && in_cmd == mrac_pkg::CMD_CLASSIFY) begin
          wptr_nxt = '0;
          unit_nxt = '0;
          step_nxt = '0;
        end
      end
      mrac_pkg::ST_HID: begin
        if (step_r != '0) begin
          wptr_nxt = wptr_r + AW'(1);
        end
        if (step_r == S_NI) begin
          step_nxt = '0;
          unit_nxt = (unit_r == U_HID_LAST) ? '0 : unit_r + UW'(1);
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      mrac_pkg::ST_WAIT_H: begin
        wptr_nxt = AW'(OW_BASE);
        unit_nxt = '0;
        step_nxt = '0;
      end
      mrac_pkg::ST_OUT: begin
        if (step_r != '0) begin
          wptr_nxt = wptr_r + AW'(1);
        end
        if (step_r == S_NH) begin
          step_nxt = '0;
          unit_nxt = (unit_r == U_OUT_LAST) ? '0 : unit_r + UW'(1);
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      default: begin
        wptr_nxt = wptr_r;
      end
    endcase
  end

  // Outputs: store write port, read addresses and the MAC control word.
  always_comb begin
    busy    = 1'b1;
    w_we    = 1'b0;
    w_waddr = wptr_r;
    w_wdata = in_param_value;
    w_raddr = wptr_r;
    h_raddr = HAW'(step_r - SW'(1));
    ctl     = '0;
    case (state_r)
      mrac_pkg::ST_INIT: begin
        w_we    = 1'b1;
        w_wdata = mrac_pkg::default_word(sec_r, 7'(unit_r), 7'(step_r));
      end
      mrac_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start && in_cmd == mrac_pkg::CMD_WRITE && 32'(in_param_index) < STORE_WORDS) begin
          w_we    = 1'b1;
          w_waddr = AW'(in_param_index);
        end
        ctl.load_feat = start && in_cmd == mrac_pkg::CMD_CLASSIFY;
      end
      mrac_pkg::ST_HID: begin
        w_raddr   = (step_r == '0) ? AW'(HB_BASE) + AW'(unit_r) : wptr_r;
        ctl.valid = 1'b1;
        ctl.first = (step_r == '0);
        ctl.last  = (step_r == S_NI);
        ctl.fidx  = IW'(step_r - SW'(1));
        ctl.unit  = IW'(unit_r);
      end
      mrac_pkg::ST_OUT: begin
        w_raddr       = (step_r == '0) ? AW'(OB_BASE) + AW'(unit_r) : wptr_r;
        ctl.valid     = 1'b1;
        ctl.first     = (step_r == '0);
        ctl.last      = (step_r == S_NH);
        ctl.out_layer = 1'b1;
        ctl.unit      = IW'(unit_r);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrac_pkg::ST_INIT;
      sec_r   <= mrac_pkg::SEC_HW;
      unit_r  <= '0;
      step_r  <= '0;
      wptr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      sec_r   <= sec_nxt;
      unit_r  <= unit_nxt;
      step_r  <= step_nxt;
      wptr_r  <= wptr_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mrac_dp.sv
// ----------------------------------------------------------------------------
// mrac_dp: multiply-accumulate datapath of the classifier
// Operand select and 16x16 multiply, 40-bit accumulate, then ReLU with
// saturation into the hidden store or a running argmax over the scores.
// ----------------------------------------------------------------------------
`default_nettype none

module mrac_dp #(
  parameter int N_INPUTS  = 9,
  parameter int N_HIDDEN  = 12,
  parameter int N_OUTPUTS = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] in_feat [mrac_pkg::FEAT_PORTS],
  input  wire mrac_pkg::mac_ctl_t                 ctl,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] w_rdata,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] h_rdata,
  output logic                                    h_we,
  output logic             [mrac_pkg::IDX_W-1:0]  h_waddr,
  output logic signed      [mrac_pkg::DATA_W-1:0] h_wdata,
  output mrac_pkg::mac_sts_t                      sts,
  output logic                                    out_valid,
  output logic             [1:0]                  out_action
);

  localparam int OW = $clog2(N_OUTPUTS);
  localparam int IW = mrac_pkg::IDX_W;

  localparam logic [IW-1:0] FEAT_LIMIT = IW'((N_INPUTS < mrac_pkg::FEAT_PORTS) ?
                                             N_INPUTS : mrac_pkg::FEAT_PORTS);
  localparam logic [IW-1:0] HID_LAST   = IW'(N_HIDDEN - 1);
  localparam logic [IW-1:0] OUT_LAST   = IW'(N_OUTPUTS - 1);

  logic signed [mrac_pkg::DATA_W-1:0] feat_r [mrac_pkg::FEAT_PORTS];
  mrac_pkg::mac_ctl_t                 ctl1_r, ctl2_r, ctl3_r;
  logic signed [mrac_pkg::DATA_W-1:0] opa;
  logic signed [mrac_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [mrac_pkg::ACC_W-1:0]  acc_r, acc_nxt, prod_ext;
  logic signed [mrac_pkg::ACC_W-1:0]  best_r;
  logic        [OW-1:0]               best_idx_r, idx_here;
  logic                               win, out_last;
  logic                               out_valid_r;
  logic        [1:0]                  out_action_r;

  // Bias words are scaled by one in Q8.8 so that they line up with products.
  always_comb begin
    if (ctl1_r.first) begin
      opa = mrac_pkg::ONE_Q88;
    end else if (ctl1_r.out_layer) begin
      opa = h_rdata;
    end else if (ctl1_r.fidx < FEAT_LIMIT) begin
      opa = feat_r[ctl1_r.fidx[mrac_pkg::FEAT_IW-1:0]];
    end else begin
      opa = '0;
    end
    prod_nxt = opa * w_rdata;
  end

  always_comb begin
    prod_ext = mrac_pkg::ACC_W'(prod_r);
    acc_nxt  = ctl2_r.first ? prod_ext : acc_r + prod_ext;
  end

  // ReLU, truncate to Q8.8 and saturate at the largest positive value.
  always_comb begin
    if (acc_r <= 0) begin
      h_wdata = '0;
    end else if (acc_r[38:23] != '0) begin
      h_wdata = 16'sh7fff;
    end else begin
      h_wdata = acc_r[23:8];
    end
    h_we         = ctl3_r.valid && ctl3_r.last && !ctl3_r.out_layer;
    h_waddr      = ctl3_r.unit;
    out_last     = ctl3_r.valid && ctl3_r.last && ctl3_r.out_layer;
    idx_here     = OW'(ctl3_r.unit);
    win          = (ctl3_r.unit == '0) || (acc_r > best_r);
    sts.hid_done = h_we && ctl3_r.unit == HID_LAST;
    sts.out_done = out_last && ctl3_r.unit == OUT_LAST;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r      <= '0;
      ctl2_r      <= '0;
      ctl3_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl1_r      <= ctl;
      ctl2_r      <= ctl1_r;
      ctl3_r      <= ctl2_r;
      out_valid_r <= sts.out_done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_feat) begin
      feat_r <= in_feat;
    end
    prod_r <= prod_nxt;
    if (ctl2_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (out_last && win) begin
      best_r     <= acc_r;
      best_idx_r <= idx_here;
    end
    if (sts.out_done) begin
      out_action_r <= 2'(win ? idx_here : best_idx_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;

endmodule

`default_nettype wire

FILE: rtl/core/mlp_relu_argmax_classifier_core.sv
// ----------------------------------------------------------------------------
// mlp_relu_argmax_classifier_core: two-layer perceptron action classifier
// Weight store, hidden store, sequencer and one shared MAC datapath.
// ----------------------------------------------------------------------------
// Classify: the result strobe of a classify word comes after both layers
//   have been read through the single weight-store read port; busy drops in
//   the strobe cycle, so a classify word is not taken until the one before it
//   has given its result. A write word is taken while idle and keeps busy low.
// Reset: the default network is loaded one word per cycle with busy high.
//   The receiver cannot stall; each result shows for one cycle.
`default_nettype none

module mlp_relu_argmax_classifier_core #(
  parameter int N_INPUTS  = 9,
  parameter int N_HIDDEN  = 12,
  parameter int N_OUTPUTS = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_cmd,
  input  wire logic        [7:0]                  in_param_index,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] in_param_value,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] in_feat_0,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] in_feat_1,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] in_feat_2,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] in_feat_3,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] in_feat_4,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] in_feat_5,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] in_feat_6,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] in_feat_7,
  input  wire logic signed [mrac_pkg::DATA_W-1:0] in_feat_8,
  output logic                                    out_valid,
  output logic             [1:0]                  out_action
);

  // The store holds hidden weights, hidden biases, output weights and output
  // biases back to back, in that order.
  localparam int STORE_WORDS = N_HIDDEN * N_INPUTS + N_HIDDEN + N_OUTPUTS * N_HIDDEN
                               + N_OUTPUTS;
  localparam int AW          = $clog2(STORE_WORDS);
  localparam int HAW         = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
  localparam int DW          = mrac_pkg::DATA_W;

  logic signed [DW-1:0]      feat [mrac_pkg::FEAT_PORTS];
  mrac_pkg::mac_ctl_t        ctl;
  mrac_pkg::mac_sts_t        sts;
  logic                      w_we;
  logic [AW-1:0]             w_waddr, w_raddr;
  logic signed [DW-1:0]      w_wdata, w_rdata;
  logic [HAW-1:0]            h_raddr;
  logic                      h_we;
  logic [mrac_pkg::IDX_W-1:0] h_waddr;
  logic signed [DW-1:0]      h_wdata, h_rdata;

  assign feat[0] = in_feat_0;
  assign feat[1] = in_feat_1;
  assign feat[2] = in_feat_2;
  assign feat[3] = in_feat_3;
  assign feat[4] = in_feat_4;
  assign feat[5] = in_feat_5;
  assign feat[6] = in_feat_6;
  assign feat[7] = in_feat_7;
  assign feat[8] = in_feat_8;

  // The sequencer owns the store write port: the default load after reset
  // and write words when idle. While a classify runs it only reads.
  mrac_seq #(
    .N_INPUTS  (N_INPUTS),
    .N_HIDDEN  (N_HIDDEN),
    .N_OUTPUTS (N_OUTPUTS),
    .AW        (AW),
    .HAW       (HAW)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_cmd         (in_cmd),
    .in_param_index (in_param_index),
    .in_param_value (in_param_value),
    .sts            (sts),
    .busy           (busy),
    .w_we           (w_we),
    .w_waddr        (w_waddr),
    .w_wdata        (w_wdata),
    .w_raddr        (w_raddr),
    .h_raddr        (h_raddr),
    .ctl            (ctl)
  );

  mrac_ram #(
    .DEPTH (STORE_WORDS),
    .AW    (AW),
    .W     (DW)
  ) u_wstore (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // Hidden values are written as each unit finishes. The sequencer waits for
  // the last one to land before the output layer starts reading.
  mrac_ram #(
    .DEPTH (N_HIDDEN),
    .AW    (HAW),
    .W     (DW)
  ) u_hstore (
    .clk   (clk),
    .we    (h_we),
    .waddr (HAW'(h_waddr)),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  mrac_dp #(
    .N_INPUTS  (N_INPUTS),
    .N_HIDDEN  (N_HIDDEN),
    .N_OUTPUTS (N_OUTPUTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_feat    (feat),
    .ctl        (ctl),
    .w_rdata    (w_rdata),
    .h_rdata    (h_rdata),
    .h_we       (h_we),
    .h_waddr    (h_waddr),
    .h_wdata    (h_wdata),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_action (out_action)
  );

endmodule

`default_nettype wire

FILE: rtl/core/mrac_checker.sv
// ----------------------------------------------------------------------------
// mrac_checker: port-level checks of the classifier core
// Result strobe timing against the command words and busy.
// ----------------------------------------------------------------------------
`default_nettype none

module mrac_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_cmd,
  input wire logic out_valid
);

  // A result is a single-cycle strobe; classifications are far apart.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == mrac_pkg::CMD_CLASSIFY) |=> busy)
    else $error("classify word taken without going busy");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == mrac_pkg::CMD_WRITE) |=> !busy)
    else $error("write word made the core busy");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a classification in progress");

endmodule

bind mlp_relu_argmax_classifier_core mrac_checker u_mrac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_cmd    (in_cmd),
  .out_valid (out_valid)
);

`default_nettype wire

FILE: bench/tb_mlp_relu_argmax_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mlp_relu_argmax_classifier_core: self-checking bench of the classifier
// Sends store-write and classify words through the start/busy handshake,
// predicts each action that is not typed in with a local fixed-point copy of
// the network, and checks every result strobe against the oldest pending action.
// ----------------------------------------------------------------------------

module tb_mlp_relu_argmax_classifier_core;

  // Network shape and layout of the weight store: hidden weights, hidden
  // biases, output weights, output biases.
  localparam int N_IN        = 9;
  localparam int N_HID       = 12;
  localparam int N_OUT       = 4;
  localparam int HB_BASE     = N_HID * N_IN;
  localparam int OW_BASE     = HB_BASE + N_HID;
  localparam int OB_BASE     = OW_BASE + N_OUT * N_HID;
  localparam int STORE_WORDS = OB_BASE + N_OUT;

  // The drain is longer than a whole classify pass, so these quiet cycles at
  // the end are enough to catch a stray result.
  localparam int DRAIN_CYCLES = 250;
  localparam int RANDOM_WORDS = 1430;
  localparam int PAUSE_AT     = 700;

  // One word as the sender presents it.
  typedef struct packed {
    logic             cmd;
    logic [7:0]       idx;
    logic [15:0]      val;
    logic [8:0][15:0] feat;
  } cmd_word_t;

  // Feature vectors used by the directed rows.
  typedef enum logic [2:0] {
    PAT_ZERO,
    PAT_ONE,
    PAT_MAX,
    PAT_MIN,
    PAT_ALT
  } feat_pat_t;

  // A directed row either carries a typed-in action (check set) or leaves
  // the expected action to the predictor.
  typedef struct packed {
    logic       cmd;
    logic [7:0] idx;
    logic [15:0] val;
    feat_pat_t  pat;
    logic       check;
    logic [1:0] action;
  } directed_row_t;

  localparam int N_DIRECTED = 22;

  // With zero features the default network lights only hidden units 3 and 4,
  // so output 3 wins. Forcing the bias of output 3 to its minimum leaves
  // outputs 1 and 2 tied at the top, and the lower index must win.
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{mrac_pkg::CMD_CLASSIFY, 8'd0,               16'h0000, PAT_ZERO, 1'b1, 2'd3},
    '{mrac_pkg::CMD_CLASSIFY, 8'd0,               16'h0000, PAT_MAX,  1'b0, 2'd0},
    '{mrac_pkg::CMD_CLASSIFY, 8'd0,               16'h0000, PAT_MIN,  1'b0, 2'd0},
    '{mrac_pkg::CMD_CLASSIFY, 8'd0,               16'h0000, PAT_ALT,  1'b0, 2'd0},
    '{mrac_pkg::CMD_WRITE,    8'd255,             16'h7FFF, PAT_MAX,  1'b0, 2'd0},
    '{mrac_pkg::CMD_WRITE,    8'(STORE_WORDS),    16'h8000, PAT_MIN,  1'b0, 2'd0},
    '{mrac_pkg::CMD_CLASSIFY, 8'd0,               16'h0000, PAT_ZERO, 1'b1, 2'd3},
    '{mrac_pkg::CMD_WRITE,    8'(OB_BASE + 3),    16'h8000, PAT_ZERO, 1'b0, 2'd0},
    '{mrac_pkg::CMD_CLASSIFY, 8'd0,               16'h0000, PAT_ZERO, 1'b1, 2'd1},
    '{mrac_pkg::CMD_WRITE,    8'd0,               16'h7FFF, PAT_ZERO, 1'b0, 2'd0},
    '{mrac_pkg::CMD_WRITE,    8'(HB_BASE),        16'h7FFF, PAT_ZERO, 1'b0, 2'd0},
    '{mrac_pkg::CMD_CLASSIFY, 8'd0,               16'h0000, PAT_ONE,  1'b0, 2'd0},
    '{mrac_pkg::CMD_CLASSIFY, 8'd0,               16'h0000, PAT_MAX,  1'b0, 2'd0},
    '{mrac_pkg::CMD_WRITE,    8'(OW_BASE),        16'h8000, PAT_ZERO, 1'b0, 2'd0},
    '{mrac_pkg::CMD_WRITE,    8'(OB_BASE + 3),    16'h7FFF, PAT_ZERO, 1'b0, 2'd0},
    '{mrac_pkg::CMD_CLASSIFY, 8'd0,               16'h0000, PAT_MAX,  1'b0, 2'd0},
    '{mrac_pkg::CMD_CLASSIFY, 8'd0,               16'h0000, PAT_MIN,  1'b0, 2'd0},
    '{mrac_pkg::CMD_CLASSIFY, 8'd0,               16'h0000, PAT_ALT,  1'b0, 2'd0},
    '{mrac_pkg::CMD_WRITE,    8'(HB_BASE - 1),    16'hFFFF, PAT_ZERO, 1'b0, 2'd0},
    '{mrac_pkg::CMD_WRITE,    8'(OW_BASE - 1),    16'h3039, PAT_ZERO, 1'b0, 2'd0},
    '{mrac_pkg::CMD_WRITE,    8'(OB_BASE - 1),    16'h8000, PAT_ZERO, 1'b0, 2'd0},
    '{mrac_pkg::CMD_CLASSIFY, 8'd0,               16'h0000, PAT_ONE,  1'b0, 2'd0}
  };

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     start          = 1'b0;
  logic                     in_cmd         = 1'b0;
  logic        [7:0]        in_param_index = '0;
  logic signed [15:0]       in_param_value = '0;
  logic signed [15:0]       in_feat_0      = '0;
  logic signed [15:0]       in_feat_1      = '0;
  logic signed [15:0]       in_feat_2      = '0;
  logic signed [15:0]       in_feat_3      = '0;
  logic signed [15:0]       in_feat_4      = '0;
  logic signed [15:0]       in_feat_5      = '0;
  logic signed [15:0]       in_feat_6      = '0;
  logic signed [15:0]       in_feat_7      = '0;
  logic signed [15:0]       in_feat_8      = '0;
  logic                     busy;
  logic                     out_valid;
  logic        [1:0]        out_action;

  // Bench copy of the weight store and the actions still owed by the block.
  logic signed [15:0] net_store [STORE_WORDS];
  logic [1:0]         pending_actions [$];

  int fail_count      = 0;
  int n_classify      = 0;
  int n_write         = 0;
  int n_write_outside = 0;
  int n_results       = 0;
  int action_seen [N_OUT];

  always #5 clk = ~clk;

  mlp_relu_argmax_classifier_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_param_index (in_param_index),
    .in_param_value (in_param_value),
    .in_feat_0      (in_feat_0),
    .in_feat_1      (in_feat_1),
    .in_feat_2      (in_feat_2),
    .in_feat_3      (in_feat_3),
    .in_feat_4      (in_feat_4),
    .in_feat_5      (in_feat_5),
    .in_feat_6      (in_feat_6),
    .in_feat_7      (in_feat_7),
    .in_feat_8      (in_feat_8),
    .out_valid      (out_valid),
    .out_action     (out_action)
  );

  // The default network as it stands after reset. Every word that is not
  // listed here starts at zero.
  task automatic load_default_network();
    for (int k = 0; k < STORE_WORDS; k++) begin
      net_store[k] = '0;
    end
    // Hidden weights, addressed unit * N_IN + feature.
    net_store[1]   = 16'sd512;   net_store[0]   = -16'sd384;  net_store[8]   = 16'sd768;
    net_store[13]  = 16'sd512;   net_store[12]  = -16'sd256;  net_store[16]  = 16'sd768;
    net_store[24]  = 16'sd1024;
    net_store[28]  = -16'sd256;  net_store[31]  = -16'sd256;  net_store[33]  = -16'sd256;
    net_store[38]  = -16'sd512;
    net_store[45]  = 16'sd77;    net_store[47]  = 16'sd128;
    net_store[61]  = 16'sd256;   net_store[58]  = 16'sd128;
    net_store[68]  = -16'sd128;  net_store[69]  = 16'sd205;
    net_store[73]  = 16'sd128;   net_store[74]  = -16'sd77;
    net_store[84]  = -16'sd77;   net_store[88]  = 16'sd128;
    net_store[90]  = 16'sd51;    net_store[96]  = -16'sd102;
    net_store[103] = 16'sd154;   net_store[102] = -16'sd77;
    // Hidden biases.
    net_store[HB_BASE + 0] = -16'sd512;
    net_store[HB_BASE + 1] = -16'sd384;
    net_store[HB_BASE + 2] = -16'sd256;
    net_store[HB_BASE + 3] = 16'sd512;
    net_store[HB_BASE + 4] = 16'sd256;
    // Output weights, addressed output * N_HID + hidden unit.
    net_store[OW_BASE + 0]  = 16'sd768;  net_store[OW_BASE + 4]  = -16'sd384;
    net_store[OW_BASE + 13] = 16'sd768;  net_store[OW_BASE + 18] = 16'sd128;
    net_store[OW_BASE + 12] = -16'sd128;
    net_store[OW_BASE + 26] = 16'sd1280; net_store[OW_BASE + 24] = -16'sd128;
    net_store[OW_BASE + 39] = 16'sd512;
    // Output biases.
    net_store[OB_BASE + 0] = -16'sd768;
    net_store[OB_BASE + 1] = -16'sd256;
    net_store[OB_BASE + 2] = -16'sd256;
    net_store[OB_BASE + 3] = -16'sd256;
  endtask

  // Forward pass in Q8.8 with a wrapping 40-bit accumulator. Biases enter
  // shifted up by 8 so they line up with the Q16.16 products. Hidden values
  // are ReLU, truncated back to Q8.8 and saturated; output scores compare at
  // full width and only a strictly greater score replaces the leader.
  function automatic logic [1:0] predict_action(input logic [8:0][15:0] feat);
    logic signed [39:0] acc;
    logic signed [39:0] best;
    logic signed [31:0] prod;
    logic signed [15:0] bias;
    logic signed [15:0] hid [N_HID];
    logic [1:0]         winner;
    best   = '0;
    winner = '0;
    for (int h = 0; h < N_HID; h++) begin
      bias = net_store[HB_BASE + h];
      acc  = {{16{bias[15]}}, bias, 8'd0};
      for (int i = 0; i < N_IN; i++) begin
        prod = signed'(feat[i]) * net_store[h * N_IN + i];
        acc  = acc + prod;
      end
      if (acc <= 0) begin
        hid[h] = '0;
      end else if ((acc >>> 8) > 40'sd32767) begin
        hid[h] = 16'sd32767;
      end else begin
        hid[h] = acc[23:8];
      end
    end
    for (int o = 0; o < N_OUT; o++) begin
      bias = net_store[OB_BASE + o];
      acc  = {{16{bias[15]}}, bias, 8'd0};
      for (int h = 0; h < N_HID; h++) begin
        prod = hid[h] * net_store[OW_BASE + o * N_HID + h];
        acc  = acc + prod;
      end
      if (o == 0 || acc > best) begin
        best   = acc;
        winner = o[1:0];
      end
    end
    return winner;
  endfunction

  function automatic logic [8:0][15:0] pattern_features(input feat_pat_t pat);
    logic [8:0][15:0] f;
    for (int i = 0; i < N_IN; i++) begin
      case (pat)
        PAT_ONE: f[i] = 16'h0100;
        PAT_MAX: f[i] = 16'h7FFF;
        PAT_MIN: f[i] = 16'h8000;
        PAT_ALT: f[i] = i[0] ? 16'h8000 : 16'h7FFF;
        default: f[i] = 16'h0000;
      endcase
    end
    return f;
  endfunction

  // Q8.8 values: the extremes and zero often, small magnitudes as a trained
  // network would see them, and the full range for the rest.
  function automatic logic [15:0] random_q88();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2:       v = 16'h0000;
      3, 4:    v = 16'($urandom_range(0, 2048)) - 16'd1024;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Roughly half the words are writes; one write in twenty aims past the end
  // of the store and must be dropped.
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    w.cmd = ($urandom_range(0, 99) < 45) ? mrac_pkg::CMD_WRITE : mrac_pkg::CMD_CLASSIFY;
    if ($urandom_range(0, 19) == 0) begin
      w.idx = 8'($urandom_range(STORE_WORDS, 255));
    end else begin
      w.idx = 8'($urandom_range(0, STORE_WORDS - 1));
    end
    w.val = random_q88();
    for (int i = 0; i < N_IN; i++) begin
      w.feat[i] = random_q88();
    end
    return w;
  endfunction

  // Most gaps are none or short, a few are long enough to land anywhere in
  // a classify pass.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(15, 80);
  endfunction

  // Presents one word and holds it until the block takes it. The prediction
  // is made at the accepting edge, so the store copy tracks the block word
  // for word.
  task automatic send_word(input cmd_word_t w, input logic check, input logic [1:0] action);
    start          <= 1'b1;
    in_cmd         <= w.cmd;
    in_param_index <= w.idx;
    in_param_value <= w.val;
    in_feat_0      <= w.feat[0];
    in_feat_1      <= w.feat[1];
    in_feat_2      <= w.feat[2];
    in_feat_3      <= w.feat[3];
    in_feat_4      <= w.feat[4];
    in_feat_5      <= w.feat[5];
    in_feat_6      <= w.feat[6];
    in_feat_7      <= w.feat[7];
    in_feat_8      <= w.feat[8];
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    if (w.cmd == mrac_pkg::CMD_CLASSIFY) begin
      pending_actions.push_back(check ? action : predict_action(w.feat));
      n_classify++;
    end else begin
      n_write++;
      if (w.idx < STORE_WORDS) begin
        net_store[w.idx] = w.val;
      end else begin
        n_write_outside++;
      end
    end
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Results are taken at the edge that ends their strobe cycle; each one
  // must match the oldest pending action.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_actions.size() == 0) begin
        $error("out_action: no classify word pending, got %0d", out_action);
        fail_count++;
      end else begin
        if (out_action !== pending_actions[0]) begin
          $error("out_action mismatch: expected %0d, got %0d",
                 pending_actions[0], out_action);
          fail_count++;
        end
        void'(pending_actions.pop_front());
        n_results++;
        action_seen[out_action]++;
      end
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    cmd_word_t w;
    int        burst_left;
    burst_left = 0;
    for (int k = 0; k < N_OUT; k++) begin
      action_seen[k] = 0;
    end
    load_default_network();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: default network, out-of-range writes, the tie, extreme
    // weights and biases, and the last word of each store section.
    for (int r = 0; r < N_DIRECTED; r++) begin
      w.cmd  = DIRECTED[r].cmd;
      w.idx  = DIRECTED[r].idx;
      w.val  = DIRECTED[r].val;
      w.feat = pattern_features(DIRECTED[r].pat);
      send_word(w, DIRECTED[r].check, DIRECTED[r].action);
      idle_gap(gap_length());
    end

    // Random words. Every so often a burst runs back to back with no gaps,
    // and halfway through the sender waits until the block has answered
    // every classify word it holds.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == PAUSE_AT) begin
        while (pending_actions.size() != 0) begin
          start <= 1'b0;
          @(posedge clk);
        end
      end
      if (n % 150 == 0) begin
        burst_left = 40;
      end
      w = random_word();
      send_word(w, 1'b0, 2'd0);
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        idle_gap(gap_length());
      end
    end
    start <= 1'b0;

    while (pending_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d classify and %0d write words (%0d outside the store); %0d actions checked.",
             n_classify, n_write, n_write_outside, n_results);
    $display("Actions seen: 0:%0d 1:%0d 2:%0d 3:%0d",
             action_seen[0], action_seen[1], action_seen[2], action_seen[3]);
    if (fail_count == 0 && pending_actions.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: mlp_relu_argmax_classifier_core.f
rtl/core/mrac_pkg.sv
rtl/core/mrac_ram.sv
rtl/core/mrac_seq.sv
rtl/core/mrac_dp.sv
rtl/core/mlp_relu_argmax_classifier_core.sv
rtl/core/mrac_checker.sv
bench/tb_mlp_relu_argmax_classifier_core.sv
